// ===== sv/positional_fifo_queue_unit_defines.svh =====
// Assertion macros used by the queue RTL.
`ifndef POSITIONAL_FIFO_QUEUE_UNIT_DEFINES_SVH
`define POSITIONAL_FIFO_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, muted while reset is high.
`define PFQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, muted while reset is high.
`define PFQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/pfq_pkg.sv =====
`default_nettype none

package pfq_pkg;

   // Request codes; codes 6 and 7 behave as peek.
   localparam logic [2:0] REQ_PUSH   = 3'd0;
   localparam logic [2:0] REQ_POP    = 3'd1;
   localparam logic [2:0] REQ_INSERT = 3'd2;
   localparam logic [2:0] REQ_DELETE = 3'd3;
   localparam logic [2:0] REQ_CLEAR  = 3'd4;
   localparam logic [2:0] REQ_PEEK   = 3'd5;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } pfq_status_type;

   // Command broadcast along the cell row.
   typedef enum logic [1:0] {
      KIND_HOLD   = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_DELETE = 2'd2
   } pfq_kind_type;

   localparam int TypeW   = 3;
   localparam int ValueW  = 32;
   localparam int PosW    = 4;
   localparam int CountW  = 5;
   localparam int ReqW    = 40;
   localparam int RspW    = 40;

endpackage

`default_nettype wire

// ===== sv/pfq_cell.sv =====
`default_nettype none

module pfq_cell
   import pfq_pkg::*;
#(
   parameter int DataW = 32,
   parameter int IdxW  = 4,
   parameter int Index = 0
) (
   input  wire logic               clock,
   input  wire pfq_kind_type       kind,
   input  wire logic [IdxW-1:0]    where,
   input  wire logic [DataW-1:0]   load_word,
   input  wire logic [DataW-1:0]   left_word,
   input  wire logic [DataW-1:0]   right_word,
   output logic      [DataW-1:0]   word_ff,
   output logic      [DataW-1:0]   word_in
);

   localparam logic [IdxW-1:0] Here = IdxW'(Index);

   always_comb begin
      word_in = word_ff;
      case (kind)
         KIND_INSERT: begin
            // take the new word at the slot, shift everything behind it back
            if (Here == where) begin
               word_in = load_word;
            end else if (Here > where) begin
               word_in = left_word;
            end
         end
         KIND_DELETE: begin
            // close the gap: the slot and all behind it pull from the right
            if (Here >= where) begin
               word_in = right_word;
            end
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

endmodule

`default_nettype wire

// ===== sv/positional_fifo_queue_unit.sv =====
// Channel   Dir  Handshake               Word contents (low bit first)
// req_      in   req_tvalid/req_tready   req_type[2:0] value[34:3] position[38:35]
// rsp_      out  rsp_tvalid/rsp_tready   front_value[31:0] count[36:32]
//                                        is_empty[37] status[39:38]
//
// Cycles: one request per cycle while no result word waits with rsp_tready low;
// a request's result word is loaded into the output register on the edge that
// accepts it and leaves once rsp_tready is high. The rate is set by the cell
// row, which loads, holds or shifts every entry together.
// Reset clears the entry count and the result valid flag; cell contents are
// not cleared, since only cells below the count are ever read.
// Stalls: req_tready drops only while a result word waits and rsp_tready is low.
`default_nettype none
`include "positional_fifo_queue_unit_defines.svh"

module positional_fifo_queue_unit
   import pfq_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // req_type[2:0], value[34:3], position[38:35], zero pad [39]
   input  wire logic [ReqW-1:0]   req_tdata,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // front_value[31:0], count[36:32], is_empty[37], status[39:38]
   output logic      [RspW-1:0]   rsp_tdata
);

   localparam int IdxW  = $clog2(DEPTH);
   localparam int OccW  = $clog2(DEPTH + 1);
   localparam int CmpW  = (OccW > PosW) ? OccW : PosW;
   localparam int FullW = (DATA_WIDTH > ValueW) ? DATA_WIDTH : ValueW;
   localparam int CntW  = (OccW > CountW) ? OccW : CountW;
   localparam logic [OccW-1:0] OccFull = OccW'(DEPTH);

   // unpack the request word
   logic [TypeW-1:0]  req_type;
   logic [ValueW-1:0] req_value;
   logic [PosW-1:0]   req_position;

   assign req_type     = req_tdata[TypeW-1:0];
   assign req_value    = req_tdata[TypeW+ValueW-1:TypeW];
   assign req_position = req_tdata[TypeW+ValueW+PosW-1:TypeW+ValueW];

   logic accept;
   assign accept = req_tvalid && req_tready;

   // entry count and result register
   logic [OccW-1:0]   occ_ff, occ_in;
   logic              rsp_valid_ff;
   logic [ValueW-1:0] front_ff;
   logic [CountW-1:0] count_ff;
   logic              empty_ff;
   pfq_status_type    status_ff;

   // decoded request
   pfq_kind_type      kind_c, kind_sel;
   logic [IdxW-1:0]   where_c;
   pfq_status_type    status_c;
   logic [OccW-1:0]   occ_c;
   logic [CmpW-1:0]   pos_cmp, occ_cmp;

   assign pos_cmp = CmpW'(req_position);
   assign occ_cmp = CmpW'(occ_ff);

   always_comb begin
      kind_c   = KIND_HOLD;
      where_c  = '0;
      status_c = ST_OK;
      occ_c    = occ_ff;
      unique case (req_type)
         REQ_PUSH: begin
            // append: an insert at the current count
            if (occ_ff == OccFull) begin
               status_c = ST_FULL;
            end else begin
               kind_c  = KIND_INSERT;
               where_c = IdxW'(occ_ff);
               occ_c   = occ_ff + 1'b1;
            end
         end
         REQ_POP: begin
            // drop the head: a delete at slot zero
            if (occ_ff == '0) begin
               status_c = ST_EMPTY;
            end else begin
               kind_c  = KIND_DELETE;
               occ_c   = occ_ff - 1'b1;
            end
         end
         REQ_INSERT: begin
            if (occ_ff == OccFull) begin
               status_c = ST_FULL;
            end else if (pos_cmp > occ_cmp) begin
               status_c = ST_RANGE;
            end else begin
               kind_c  = KIND_INSERT;
               where_c = IdxW'(pos_cmp);
               occ_c   = occ_ff + 1'b1;
            end
         end
         REQ_DELETE: begin
            if (occ_ff == '0) begin
               status_c = ST_EMPTY;
            end else if (pos_cmp >= occ_cmp) begin
               status_c = ST_RANGE;
            end else begin
               kind_c  = KIND_DELETE;
               where_c = IdxW'(pos_cmp);
               occ_c   = occ_ff - 1'b1;
            end
         end
         REQ_CLEAR: begin
            occ_c = '0;
         end
         default: begin
            // peek and the unused codes leave the queue alone
            occ_c = occ_ff;
         end
      endcase
   end

   // hold the cells unless a request is actually taken
   assign kind_sel = accept ? kind_c : KIND_HOLD;
   assign occ_in   = accept ? occ_c : occ_ff;

   // word to store: low DATA_WIDTH bits of the request value
   logic [FullW-1:0]      value_wide;
   logic [DATA_WIDTH-1:0] load_word;
   assign value_wide = FullW'(req_value);
   assign load_word  = value_wide[DATA_WIDTH-1:0];

   // cell row, head in cell zero
   logic [DATA_WIDTH-1:0] cell_q  [DEPTH];
   logic [DATA_WIDTH-1:0] cell_n  [DEPTH];
   logic [DATA_WIDTH-1:0] left_w  [DEPTH];
   logic [DATA_WIDTH-1:0] right_w [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_w[i] = load_word;
      end else begin : g_left
         assign left_w[i] = cell_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_w[i] = '0;
      end else begin : g_right
         assign right_w[i] = cell_q[i+1];
      end

      pfq_cell #(
         .DataW (DATA_WIDTH),
         .IdxW  (IdxW),
         .Index (i)
      ) u_cell (
         .clock      (clock),
         .kind       (kind_sel),
         .where      (where_c),
         .load_word  (load_word),
         .left_word  (left_w[i]),
         .right_word (right_w[i]),
         .word_ff    (cell_q[i]),
         .word_in    (cell_n[i])
      );
   end

   // result fields from the state after the request
   logic [FullW-1:0] head_wide;
   logic [CntW-1:0]  count_wide;
   assign head_wide  = (occ_c != '0) ? FullW'(cell_n[0]) : '0;
   assign count_wide = CntW'(occ_c);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         front_ff  <= head_wide[ValueW-1:0];
         count_ff  <= count_wide[CountW-1:0];
         empty_ff  <= (occ_c == '0);
         status_ff <= status_c;
      end
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {status_ff, empty_ff, count_ff, front_ff};

   // checks
   logic [CntW-1:0] occ_now_wide;
   assign occ_now_wide = CntW'(occ_ff);

   `PFQ_ASSERT_NOW(a_occ_bound, clock, reset, 1'b1, occ_ff <= OccFull, "count exceeds depth")
   `PFQ_ASSERT_NOW(a_rsp_matches_occ, clock, reset, rsp_valid_ff, (count_ff == occ_now_wide[CountW-1:0]) && (empty_ff == (occ_ff == '0)), "pending result disagrees with count")
   `PFQ_ASSERT_NEXT(a_refused_holds, clock, reset, accept && (status_c != ST_OK), $stable(occ_ff), "refused request changed count")
   `PFQ_ASSERT_NEXT(a_clear_empties, clock, reset, accept && (req_type == REQ_CLEAR), occ_ff == '0, "clear left entries")

endmodule

`default_nettype wire
